>>> rtl/mgb_pkg.sv
package mgb_pkg;

	// grid geometry
	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int PIXEL_BITS = 8;

	// each of the four banks holds one row/column parity class
	localparam int HROW_BITS = $clog2(MAX_ROWS) - 1;
	localparam int HCOL_BITS = $clog2(MAX_COLS) - 1;
	localparam int ADDR_BITS = HROW_BITS + HCOL_BITS;
	localparam int BANKS     = 4;

	// register widths
	localparam int DIM_BITS = 7;
	localparam int CFG_BITS = 7;

	// signed coordinate wide enough for 2*block_index+1 and pixel rows
	localparam int COORD_BITS = 9;

	typedef logic [PIXEL_BITS-1:0]        pix_t;
	typedef logic [ADDR_BITS-1:0]         addr_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIM_BITS-1:0]          dim_t;
	typedef logic [1:0]                   bank_t;

	// action codes
	localparam logic [2:0] ACT_WR_PIX  = 3'd0;
	localparam logic [2:0] ACT_RD_PIX  = 3'd1;
	localparam logic [2:0] ACT_RD_BLK  = 3'd2;
	localparam logic [2:0] ACT_WR_BLK  = 3'd3;
	localparam logic [2:0] ACT_ROT_BLK = 3'd4;
	localparam logic [2:0] ACT_PHASE   = 3'd5;

	// register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

endpackage

>>> rtl/mgb_pixel_ram.sv
module mgb_pixel_ram (
	input  logic          clk,
	input  logic          we,
	input  mgb_pkg::addr_t waddr,
	input  mgb_pkg::pix_t  wdata,
	input  mgb_pkg::addr_t raddr,
	output mgb_pkg::pix_t  rdata
);
	import mgb_pkg::*;

	localparam int DEPTH = 1 << ADDR_BITS;

	pix_t mem [DEPTH];
	pix_t rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/margolus_block_grid_store_core.sv
// an accepted request passes stage 1, then its result is registered and strobed on done
// no new request is taken while one is in stage 1 (bank read, then write-back of the grid)
// the receiver cannot stall: each result is shown for exactly one cycle
// reset: phase 0, 64x64 visible grid; busy stays high after reset
// while a clearing pass zeroes all four pixel banks
module margolus_block_grid_store_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            action,
	input  logic signed [7:0]     row,
	input  logic signed [7:0]     col,
	input  logic [5:0]            block_row,
	input  logic [5:0]            block_col,
	input  logic [7:0]            in_pixel0,
	input  logic [7:0]            in_pixel1,
	input  logic [7:0]            in_pixel2,
	input  logic [7:0]            in_pixel3,
	input  logic                  clockwise,
	output logic                  done,
	output logic [7:0]            out_pixel0,
	output logic [7:0]            out_pixel1,
	output logic [7:0]            out_pixel2,
	output logic [7:0]            out_pixel3,
	output logic                  phase_now,
	output logic                  status,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [mgb_pkg::CFG_BITS-1:0] cfg_data
);
	import mgb_pkg::*;

	localparam dim_t MAX_R = dim_t'(MAX_ROWS);
	localparam dim_t MAX_C = dim_t'(MAX_COLS);

	logic  accept;
	logic  clr_q;
	addr_t clr_cnt_q;
	logic  phase_q;
	dim_t  rows_q;
	dim_t  cols_q;

	dim_t  eff_rows;
	dim_t  eff_cols;
	logic [DIM_BITS:0] num_r;
	logic [DIM_BITS:0] num_c;
	logic  is_block;
	logic  is_pixel;
	logic  oor;
	coord_t r0;
	coord_t c0;
	coord_t cell_r [BANKS];
	coord_t cell_c [BANKS];
	logic  act_c  [BANKS];
	logic  vis_c  [BANKS];
	bank_t bank_c [BANKS];
	addr_t addr_c [BANKS];
	addr_t rd_addr [BANKS];

	// stage 1 command
	logic       valid_s1;
	logic [2:0] action_s1;
	logic       oor_s1;
	logic       cw_s1;
	pix_t       inp_s1  [BANKS];
	logic       vis_s1  [BANKS];
	bank_t      bank_s1 [BANKS];
	addr_t      addr_s1 [BANKS];

	pix_t  rd_data [BANKS];
	pix_t  cur     [BANKS];
	pix_t  nv      [BANKS];
	pix_t  res     [BANKS];
	logic  wr_cell;
	logic  ram_we    [BANKS];
	addr_t ram_waddr [BANKS];
	pix_t  ram_wdata [BANKS];

	// output registers
	logic  done_q;
	pix_t  out_q [BANKS];
	logic  phase_now_q;
	logic  status_q;

	assign busy   = clr_q | valid_s1;
	assign accept = start & ~busy;

	// visible extent and block count
	always_comb begin
		eff_rows = (rows_q > MAX_R) ? MAX_R : rows_q;
		eff_cols = (cols_q > MAX_C) ? MAX_C : cols_q;
		num_r = ({1'b0, eff_rows} + (DIM_BITS+1)'(1) + (DIM_BITS+1)'(phase_q)) >> 1;
		num_c = ({1'b0, eff_cols} + (DIM_BITS+1)'(1) + (DIM_BITS+1)'(phase_q)) >> 1;
		is_pixel = (action == ACT_WR_PIX) || (action == ACT_RD_PIX);
		is_block = (action == ACT_RD_BLK) || (action == ACT_WR_BLK) ||
			(action == ACT_ROT_BLK);
		oor = ((DIM_BITS+1)'(block_row) >= num_r) || ((DIM_BITS+1)'(block_col) >= num_c);
		r0 = coord_t'({block_row, 1'b0}) - coord_t'(phase_q);
		c0 = coord_t'({block_col, 1'b0}) - coord_t'(phase_q);
	end

	// cell coordinates, visibility and bank placement
	always_comb begin
		for (int i = 0; i < BANKS; i++) begin
			if (is_pixel) begin
				cell_r[i] = coord_t'(row);
				cell_c[i] = coord_t'(col);
				act_c[i]  = (i == 0);
			end else begin
				cell_r[i] = r0 + coord_t'(i / 2);
				cell_c[i] = c0 + coord_t'(i % 2);
				act_c[i]  = is_block && !oor;
			end
			vis_c[i] = act_c[i] &&
				!cell_r[i][COORD_BITS-1] &&
				(cell_r[i][COORD_BITS-2:0] < {1'b0, eff_rows}) &&
				!cell_c[i][COORD_BITS-1] &&
				(cell_c[i][COORD_BITS-2:0] < {1'b0, eff_cols});
			bank_c[i] = {cell_r[i][0], cell_c[i][0]};
			addr_c[i] = {cell_r[i][HROW_BITS:1], cell_c[i][HCOL_BITS:1]};
		end
	end

	// read address for each bank from the cell that lands there
	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			rd_addr[b] = '0;
			for (int i = 0; i < BANKS; i++) begin
				if (act_c[i] && bank_c[i] == bank_t'(b)) begin
					rd_addr[b] = addr_c[i];
				end
			end
		end
	end

	// configuration, phase and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= MAX_R;
			cols_q    <= MAX_C;
			phase_q   <= 1'b0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS: rows_q <= cfg_data;
					REG_COLS: cols_q <= cfg_data;
					default:  rows_q <= rows_q;
				endcase
			end
			if (valid_s1 && action_s1 == ACT_PHASE) begin
				phase_q <= ~phase_q;
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + addr_t'(1);
				if (&clr_cnt_q) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			oor_s1    <= is_block && oor;
			cw_s1     <= clockwise;
			inp_s1[0] <= in_pixel0;
			inp_s1[1] <= in_pixel1;
			inp_s1[2] <= in_pixel2;
			inp_s1[3] <= in_pixel3;
			for (int i = 0; i < BANKS; i++) begin
				vis_s1[i]  <= vis_c[i];
				bank_s1[i] <= bank_c[i];
				addr_s1[i] <= addr_c[i];
			end
		end
	end

	// pixel banks, one per row/column parity
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		mgb_pixel_ram u_ram (
			.clk   (clk),
			.we    (ram_we[b]),
			.waddr (ram_waddr[b]),
			.wdata (ram_wdata[b]),
			.raddr (rd_addr[b]),
			.rdata (rd_data[b])
		);
	end

	// modify: current cells, new cells and results
	always_comb begin
		for (int i = 0; i < BANKS; i++) begin
			cur[i] = vis_s1[i] ? rd_data[bank_s1[i]] : '0;
		end
		for (int i = 0; i < BANKS; i++) begin
			nv[i] = cur[i];
		end
		wr_cell = 1'b0;
		unique case (action_s1)
			ACT_WR_PIX: begin
				nv[0]   = inp_s1[0];
				wr_cell = 1'b1;
			end
			ACT_WR_BLK: begin
				for (int i = 0; i < BANKS; i++) begin
					nv[i] = inp_s1[i];
				end
				wr_cell = 1'b1;
			end
			ACT_ROT_BLK: begin
				if (cw_s1) begin
					nv[0] = cur[2];
					nv[1] = cur[0];
					nv[2] = cur[3];
					nv[3] = cur[1];
				end else begin
					nv[0] = cur[1];
					nv[1] = cur[3];
					nv[2] = cur[0];
					nv[3] = cur[2];
				end
				wr_cell = 1'b1;
			end
			default: wr_cell = 1'b0;
		endcase
		for (int i = 0; i < BANKS; i++) begin
			res[i] = vis_s1[i] ? nv[i] : '0;
		end
	end

	// write-back, or zero fill during the clearing pass
	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			ram_we[b]    = clr_q;
			ram_waddr[b] = clr_cnt_q;
			ram_wdata[b] = '0;
			if (!clr_q) begin
				for (int i = 0; i < BANKS; i++) begin
					if (valid_s1 && wr_cell && vis_s1[i] && bank_s1[i] == bank_t'(b)) begin
						ram_we[b]    = 1'b1;
						ram_waddr[b] = addr_s1[i];
						ram_wdata[b] = nv[i];
					end
				end
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int i = 0; i < BANKS; i++) begin
				out_q[i] <= res[i];
			end
			phase_now_q <= (action_s1 == ACT_PHASE) ? ~phase_q : phase_q;
			status_q    <= oor_s1;
		end
	end

	assign done       = done_q;
	assign out_pixel0 = out_q[0];
	assign out_pixel1 = out_q[1];
	assign out_pixel2 = out_q[2];
	assign out_pixel3 = out_q[3];
	assign phase_now  = phase_now_q;
	assign status     = status_q;

endmodule

>>> verif/mgb_result_checker.sv
`timescale 1ns / 1ps
module mgb_result_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [2:0]        action,
	input  logic signed [7:0] row,
	input  logic signed [7:0] col,
	input  logic [5:0]        block_row,
	input  logic [5:0]        block_col,
	input  logic [7:0]        in_pixel0,
	input  logic [7:0]        in_pixel1,
	input  logic [7:0]        in_pixel2,
	input  logic [7:0]        in_pixel3,
	input  logic              clockwise,
	input  logic              done,
	input  logic [7:0]        out_pixel0,
	input  logic [7:0]        out_pixel1,
	input  logic [7:0]        out_pixel2,
	input  logic [7:0]        out_pixel3,
	input  logic              phase_now,
	input  logic              status,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [mgb_pkg::CFG_BITS-1:0] cfg_data,
	output int                mismatches,
	output int                outstanding
);
	import mgb_pkg::*;

	typedef struct packed {
		pix_t pix0;
		pix_t pix1;
		pix_t pix2;
		pix_t pix3;
		logic phase;
		logic range_err;
	} grid_result_t;

	// shadow copy of the grid, the partition phase and the visible size
	pix_t cells [MAX_ROWS*MAX_COLS];
	logic cur_phase;
	dim_t rows_reg;
	dim_t cols_reg;

	grid_result_t expected_results [$];
	grid_result_t head;
	grid_result_t fresh;

	initial mismatches = 0;

	function automatic int visible_rows();
		return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int visible_cols();
		return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	function automatic bit on_grid(int r, int c);
		return r >= 0 && c >= 0 && r < visible_rows() && c < visible_cols();
	endfunction

	// gutter cells read blank and swallow writes
	function automatic pix_t peek(int r, int c);
		if (!on_grid(r, c))
			return '0;
		return cells[r*MAX_COLS + c];
	endfunction

	task automatic poke(int r, int c, pix_t v);
		if (on_grid(r, c))
			cells[r*MAX_COLS + c] = v;
	endtask

	// apply the request on the ports to the shadow grid and form its result
	task automatic apply_grid_action(output grid_result_t res);
		int   num_r;
		int   num_c;
		int   r0;
		int   c0;
		pix_t blk [4];
		pix_t tmp;
		res = '0;
		case (action)
			ACT_WR_PIX: begin
				poke(int'(row), int'(col), in_pixel0);
				res.pix0 = peek(int'(row), int'(col));
			end
			ACT_RD_PIX: begin
				res.pix0 = peek(int'(row), int'(col));
			end
			ACT_RD_BLK, ACT_WR_BLK, ACT_ROT_BLK: begin
				num_r = (visible_rows() + 1 + int'(cur_phase)) / 2;
				num_c = (visible_cols() + 1 + int'(cur_phase)) / 2;
				if (int'(block_row) >= num_r || int'(block_col) >= num_c) begin
					res.range_err = 1'b1;
				end else begin
					r0 = 2*int'(block_row) - int'(cur_phase);
					c0 = 2*int'(block_col) - int'(cur_phase);
					for (int i = 0; i < 4; i++)
						blk[i] = peek(r0 + i/2, c0 + i%2);
					if (action == ACT_WR_BLK) begin
						blk = '{in_pixel0, in_pixel1, in_pixel2, in_pixel3};
					end else if (action == ACT_ROT_BLK) begin
						tmp = blk[0];
						if (clockwise) begin
							blk[0] = blk[2]; blk[2] = blk[3]; blk[3] = blk[1]; blk[1] = tmp;
						end else begin
							blk[0] = blk[1]; blk[1] = blk[3]; blk[3] = blk[2]; blk[2] = tmp;
						end
					end
					if (action != ACT_RD_BLK)
						for (int i = 0; i < 4; i++)
							poke(r0 + i/2, c0 + i%2, blk[i]);
					// read back so that data pushed into the gutter shows as blank
					for (int i = 0; i < 4; i++)
						blk[i] = peek(r0 + i/2, c0 + i%2);
					res.pix0 = blk[0];
					res.pix1 = blk[1];
					res.pix2 = blk[2];
					res.pix3 = blk[3];
				end
			end
			ACT_PHASE: begin
				cur_phase = ~cur_phase;
			end
			default: ;
		endcase
		res.phase = cur_phase;
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// results first, then register writes, then the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (cells[i])
				cells[i] = '0;
			cur_phase = 1'b0;
			rows_reg = dim_t'(MAX_ROWS);
			cols_reg = dim_t'(MAX_COLS);
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result strobed with no request outstanding");
					mismatches++;
				end else begin
					head = expected_results.pop_front();
					check_field("out_pixel0", head.pix0, out_pixel0);
					check_field("out_pixel1", head.pix1, out_pixel1);
					check_field("out_pixel2", head.pix2, out_pixel2);
					check_field("out_pixel3", head.pix3, out_pixel3);
					check_field("phase_now", head.phase, phase_now);
					check_field("status", head.range_err, status);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if (start && !busy) begin
				apply_grid_action(fresh);
				expected_results.push_back(fresh);
			end
			outstanding = expected_results.size();
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import mgb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_SETUPS  = 9;
	localparam int QUIET_SETUP = 2;
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]        act;
		logic signed [7:0] r;
		logic signed [7:0] c;
		logic [5:0]        br;
		logic [5:0]        bc;
		logic [7:0]        p0;
		logic [7:0]        p1;
		logic [7:0]        p2;
		logic [7:0]        p3;
		logic              cw;
	} grid_req_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        action;
	logic signed [7:0] row;
	logic signed [7:0] col;
	logic [5:0]        block_row;
	logic [5:0]        block_col;
	logic [7:0]        in_pixel0;
	logic [7:0]        in_pixel1;
	logic [7:0]        in_pixel2;
	logic [7:0]        in_pixel3;
	logic              clockwise;
	logic              done;
	logic [7:0]        out_pixel0;
	logic [7:0]        out_pixel1;
	logic [7:0]        out_pixel2;
	logic [7:0]        out_pixel3;
	logic              phase_now;
	logic              status;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	int                mismatches;
	int                outstanding;

	// grid sizes per phase of the run, including a zero and an oversize register
	int setup_rows  [NUM_SETUPS] = '{64, 1, 5, 1, 0, 127, 9, 33, 64};
	int setup_cols  [NUM_SETUPS] = '{64, 1, 7, 64, 127, 127, 4, 64, 1};
	int setup_items [NUM_SETUPS] = '{300, 100, 250, 150, 100, 150, 250, 150, 100};

	int vis_rows;
	int vis_cols;
	int cycle_count = 0;
	bit idling_on;

	margolus_block_grid_store_core i_dut (.*);

	mgb_result_checker i_checker (.*);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic grid_req_t make_req(logic [2:0] act, int r, int c, int br, int bc,
			int p0, int p1, int p2, int p3, int cw);
		grid_req_t q;
		q.act = act;
		q.r = 8'(r);
		q.c = 8'(c);
		q.br = 6'(br);
		q.bc = 6'(bc);
		q.p0 = 8'(p0);
		q.p1 = 8'(p1);
		q.p2 = 8'(p2);
		q.p3 = 8'(p3);
		q.cw = 1'(cw);
		return q;
	endfunction

	// pixel coordinate: gutter on either side, the last line, any byte, or a small window
	function automatic logic signed [7:0] pick_coord(int lim);
		case ($urandom_range(0, 9))
			0: return -8'sd1;
			1: return 8'(lim);
			2: return 8'(lim - 1);
			3: return 8'($urandom_range(0, 255));
			default: return (lim > 0) ? 8'($urandom_range(0, (lim < 6 ? lim : 6) - 1)) : 8'd0;
		endcase
	endfunction

	// block index: around the range limit for either phase, any index, or near the origin
	function automatic logic [5:0] pick_block(int lim);
		int top_idx = (lim + 2) / 2;
		case ($urandom_range(0, 7))
			0: return 6'(top_idx);
			1: return 6'(top_idx - 1);
			2: return 6'($urandom_range(0, 63));
			default: return 6'($urandom_range(0, top_idx < 3 ? top_idx : 3));
		endcase
	endfunction

	function automatic grid_req_t random_request();
		grid_req_t q;
		int pick;
		q.p0 = 8'($urandom_range(0, 255));
		q.p1 = 8'($urandom_range(0, 255));
		q.p2 = 8'($urandom_range(0, 255));
		q.p3 = 8'($urandom_range(0, 255));
		q.cw = 1'($urandom_range(0, 1));
		q.r = pick_coord(vis_rows);
		q.c = pick_coord(vis_cols);
		q.br = pick_block(vis_rows);
		q.bc = pick_block(vis_cols);
		pick = $urandom_range(0, 99);
		if (pick < 20)
			q.act = ACT_WR_PIX;
		else if (pick < 35)
			q.act = ACT_RD_PIX;
		else if (pick < 50)
			q.act = ACT_RD_BLK;
		else if (pick < 68)
			q.act = ACT_WR_BLK;
		else if (pick < 86)
			q.act = ACT_ROT_BLK;
		else if (pick < 94)
			q.act = ACT_PHASE;
		else
			q.act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
		return q;
	endfunction

	// present one request from a falling edge and hold it until accepted
	task automatic issue(input grid_req_t q);
		start = 1'b1;
		action = q.act;
		row = q.r;
		col = q.c;
		block_row = q.br;
		block_col = q.bc;
		in_pixel0 = q.p0;
		in_pixel1 = q.p1;
		in_pixel2 = q.p2;
		in_pixel3 = q.p3;
		clockwise = q.cw;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		if (idling_on && $urandom_range(0, 99) < 33) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	// wait until every expected result has come back and the block is idle
	task automatic drain();
		start = 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_BITS'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_ROWS)
			vis_rows = (val > MAX_ROWS) ? MAX_ROWS : val;
		else
			vis_cols = (val > MAX_COLS) ? MAX_COLS : val;
	endtask

	// corners, gutters, rotations and range limits on the reset-size grid
	task automatic run_directed();
		issue(make_req(ACT_WR_PIX, 0, 0, 0, 0, 255, 0, 0, 0, 0));
		issue(make_req(ACT_RD_PIX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_WR_PIX, 63, 63, 0, 0, 165, 0, 0, 0, 0));
		issue(make_req(ACT_RD_PIX, 63, 63, 0, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_WR_PIX, -1, 5, 0, 0, 77, 0, 0, 0, 1));
		issue(make_req(ACT_RD_PIX, -1, 5, 0, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_WR_PIX, 64, 2, 0, 0, 9, 0, 0, 0, 0));
		issue(make_req(ACT_RD_PIX, 5, 64, 0, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_WR_PIX, -128, 127, 0, 0, 90, 0, 0, 0, 0));
		issue(make_req(ACT_WR_BLK, 0, 0, 0, 0, 1, 2, 3, 4, 0));
		issue(make_req(ACT_ROT_BLK, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		issue(make_req(ACT_ROT_BLK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_RD_BLK, 0, 0, 31, 31, 0, 0, 0, 0, 0));
		// even phase: 32 blocks per side, so index 32 is out of range
		issue(make_req(ACT_RD_BLK, 0, 0, 32, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_WR_BLK, 0, 0, 0, 63, 255, 255, 255, 255, 1));
		issue(make_req(ACT_PHASE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// odd phase: block 0 hangs over the top-left gutter
		issue(make_req(ACT_RD_BLK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_ROT_BLK, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		issue(make_req(ACT_RD_BLK, 0, 0, 32, 32, 0, 0, 0, 0, 0));
		issue(make_req(ACT_WR_BLK, 0, 0, 32, 32, 255, 128, 1, 127, 0));
		issue(make_req(ACT_RD_BLK, 0, 0, 63, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_SPARE_LO, 3, 3, 1, 1, 255, 255, 255, 255, 1));
		issue(make_req(ACT_SPARE_HI, -1, -1, 63, 63, 0, 0, 0, 0, 0));
		issue(make_req(ACT_PHASE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		issue(make_req(ACT_RD_PIX, 0, 1, 0, 0, 0, 0, 0, 0, 0));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_WR_PIX;
		row = '0;
		col = '0;
		block_row = '0;
		block_col = '0;
		in_pixel0 = '0;
		in_pixel1 = '0;
		in_pixel2 = '0;
		in_pixel3 = '0;
		clockwise = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		idling_on = 1'b1;
		vis_rows = MAX_ROWS;
		vis_cols = MAX_COLS;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// let the clearing pass finish
		while (busy)
			@(negedge clk);

		run_directed();

		for (int s = 0; s < NUM_SETUPS; s++) begin
			drain();
			write_reg(REG_ROWS, setup_rows[s]);
			write_reg(REG_COLS, setup_cols[s]);
			idling_on = (s != QUIET_SETUP);
			for (int n = 0; n < setup_items[s]; n++) begin
				// hold off mid-run until the pipeline is empty
				if (s == 0 && n == 150)
					drain();
				issue(random_request());
			end
		end

		drain();
		repeat (4) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
